// ===== src/ffc_pkg.sv =====
// Shared constants and types for the float format converter.
`default_nettype none
package ffc_pkg;

  // Source format codes
  localparam logic [1:0] FMT_BF16  = 2'd0;
  localparam logic [1:0] FMT_F16   = 2'd1;
  localparam logic [1:0] FMT_F32   = 2'd2;
  localparam logic [1:0] FMT_UNSUP = 2'd3;

  // Target format codes
  localparam logic TGT_HALF   = 1'b0;
  localparam logic TGT_SINGLE = 1'b1;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 8;
  localparam int unsigned CfgDataW = 2;
  localparam logic [CfgIdxW-1:0] REG_SOURCE_FORMAT = 8'd0;
  localparam logic [CfgIdxW-1:0] REG_TARGET_FORMAT = 8'd1;

  // Reset values of the registers
  localparam logic [1:0] SOURCE_FORMAT_RST = FMT_F32;
  localparam logic       TARGET_FORMAT_RST = TGT_HALF;

  // Exponent field bounds for single to half narrowing
  localparam logic [7:0] EXP_ALL_ONES = 8'hff;
  localparam logic [7:0] EXP_OVF_MIN  = 8'd143; // half exponent >= 31
  localparam logic [7:0] EXP_NRM_MIN  = 8'd113; // half exponent >= 1
  localparam logic [7:0] EXP_SUB_MIN  = 8'd102; // half exponent >= -10
  localparam logic [7:0] EXP_RND_BASE = 8'd125; // round bit position is 125 - exp

  localparam logic [15:0] HALF_SIGN  = 16'h8000;
  localparam logic [15:0] HALF_INF   = 16'h7c00;
  localparam logic [15:0] HALF_QUIET = 16'h0200;

  typedef struct packed {
    logic [31:0] word;
    logic        error;
  } conv_res_t;

endpackage
`default_nettype wire

// ===== src/ffc_s2h.sv =====
// Binary32 to binary16 narrowing, round to nearest even.
`default_nettype none
module ffc_s2h
  import ffc_pkg::*;
(
  input  wire logic [31:0] single_i,
  output logic      [15:0] half_o
);

  logic        sign;
  logic [7:0]  efield;
  logic [22:0] mant;
  logic [23:0] mant_full;
  logic [4:0]  rnd_pos;
  logic [23:0] shifted;
  logic [23:0] low_mask;
  logic        sub_sticky;
  logic [10:0] sub_h;
  logic        sub_up;
  logic [15:0] nrm_h;
  logic        nrm_up;
  logic [7:0]  rnd_pos_w;
  logic [4:0]  nrm_exp;

  always_comb begin
    sign      = single_i[31];
    efield    = single_i[30:23];
    mant      = single_i[22:0];
    mant_full = {1'b1, mant};

    // Subnormal path: round bit sits at position 125 - efield (13..23)
    rnd_pos_w  = EXP_RND_BASE - efield;
    rnd_pos    = rnd_pos_w[4:0];
    shifted    = mant_full >> rnd_pos;
    low_mask   = (24'd1 << rnd_pos) - 24'd1;
    sub_sticky = |(mant_full & low_mask);
    sub_h      = shifted[11:1];
    sub_up     = shifted[0] & (sub_sticky | sub_h[0]);

    // Normal path
    nrm_exp = 5'(efield - 8'd112);
    nrm_h   = {sign, nrm_exp, mant[22:13]};
    nrm_up  = mant[12] & ((|mant[11:0]) | nrm_h[0]);

    if (efield == EXP_ALL_ONES) begin
      half_o = {sign, 15'd0} | HALF_INF | ((mant != 23'd0) ? HALF_QUIET : 16'd0);
    end else if (efield >= EXP_OVF_MIN) begin
      half_o = {sign, 15'd0} | HALF_INF;
    end else if (efield < EXP_SUB_MIN) begin
      half_o = {sign, 15'd0};
    end else if (efield < EXP_NRM_MIN) begin
      // carry out of the subnormal range lands on the smallest normal
      half_o = {sign, 15'd0} | 16'({5'd0, sub_h} + {15'd0, sub_up});
    end else begin
      half_o = nrm_h + {15'd0, nrm_up};
    end
  end

endmodule
`default_nettype wire

// ===== src/ffc_convert.sv =====
// Format selection around the narrowing unit.
`default_nettype none
module ffc_convert
  import ffc_pkg::*;
(
  input  wire logic [31:0] raw_word_i,
  input  wire logic [1:0]  source_format_i,
  input  wire logic        target_format_i,
  output conv_res_t        res_o
);

  logic [31:0] s2h_in;
  logic [15:0] s2h_out;

  // bf16 is widened by appending sixteen zeros
  assign s2h_in = (source_format_i == FMT_BF16) ? {raw_word_i[15:0], 16'd0} : raw_word_i;

  ffc_s2h u_s2h (
    .single_i (s2h_in),
    .half_o   (s2h_out)
  );

  always_comb begin
    res_o.word  = 32'd0;
    res_o.error = 1'b0;
    if (target_format_i == TGT_HALF) begin
      case (source_format_i)
        FMT_BF16, FMT_F32: res_o.word = {16'd0, s2h_out};
        FMT_F16:           res_o.word = {16'd0, raw_word_i[15:0]};
        default:           res_o.error = 1'b1;
      endcase
    end else begin
      case (source_format_i)
        FMT_BF16: res_o.word = {raw_word_i[15:0], 16'd0};
        FMT_F32:  res_o.word = raw_word_i;
        default:  res_o.error = 1'b1;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== src/float_format_converter_core.sv =====
// Top level of the float format converter: registers, handshakes and datapath.
// Usage:
//   Input channel: in_valid_i / in_stall_o carry raw_word_i and last_in_i.
//   A beat is taken when in_valid_i is high and in_stall_o is low.
//   Output channel: out_valid_o / out_stall_i carry result_word_o,
//   format_error_o and last_out_o; a beat leaves when out_stall_i is low.
//   Config channel: cfg_valid_i / cfg_ready_o with cfg_index_i and
//   cfg_data_i. Index 0 is source_format, index 1 target_format; other
//   indexes are ignored. cfg_ready_o is always high. Write only while idle.
// Timing:
//   Two register stages: input register, then conversion logic, then the
//   result register, where out_valid_o rises as a taken beat arrives.
//   Throughput is one beat per cycle while out_stall_i is low, set by the
//   single-pass datapath between the two registers.
// Reset:
//   Both stages empty, source_format = f32, target_format = half.
// Backpressure:
//   While out_stall_i is high the result holds; an empty input register
//   still takes one more beat, then in_stall_o rises.
`default_nettype none
module float_format_converter_core
  import ffc_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // input channel
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic [31:0]         raw_word_i,
  input  wire logic                last_in_i,
  // output channel
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic      [31:0]         result_word_o,
  output logic                     format_error_o,
  output logic                     last_out_o,
  // configuration channel
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

  logic [1:0]  src_fmt_q;
  logic        tgt_fmt_q;

  logic        s1_valid_q;
  logic [31:0] s1_raw_q;
  logic        s1_last_q;

  logic        s2_valid_q;
  logic [31:0] s2_word_q;
  logic        s2_err_q;
  logic        s2_last_q;

  logic        s2_free;
  logic        s1_free;
  logic        s1_move;
  logic        in_take;
  conv_res_t   conv;

  assign cfg_ready_o = 1'b1;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_fmt_q <= SOURCE_FORMAT_RST;
      tgt_fmt_q <= TARGET_FORMAT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == REG_SOURCE_FORMAT) begin
        src_fmt_q <= cfg_data_i[1:0];
      end else if (cfg_index_i == REG_TARGET_FORMAT) begin
        tgt_fmt_q <= cfg_data_i[0];
      end
    end
  end

  // Stage advance
  assign s2_free    = !s2_valid_q || !out_stall_i;
  assign s1_move    = s1_valid_q && s2_free;
  assign s1_free    = !s1_valid_q || s2_free;
  assign in_stall_o = !s1_free;
  assign in_take    = in_valid_i && s1_free;

  ffc_convert u_convert (
    .raw_word_i      (s1_raw_q),
    .source_format_i (src_fmt_q),
    .target_format_i (tgt_fmt_q),
    .res_o           (conv)
  );

  // Stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_valid_q <= in_valid_i;
      end
      if (s2_free) begin
        s2_valid_q <= s1_valid_q;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_raw_q  <= raw_word_i;
      s1_last_q <= last_in_i;
    end
    if (s1_move) begin
      s2_word_q <= conv.word;
      s2_err_q  <= conv.error;
      s2_last_q <= s1_last_q;
    end
  end

  assign out_valid_o    = s2_valid_q;
  assign result_word_o  = s2_word_q;
  assign format_error_o = s2_err_q;
  assign last_out_o     = s2_last_q;

endmodule
`default_nettype wire
